@@ rtl/mgr3d_pkg.sv @@
// ----------------------------------------------------------------------------
// mgr3d_pkg
// Shared types and constants for the periodic 3-D restriction block.
// ----------------------------------------------------------------------------
package mgr3d_pkg;

  localparam int MAX_FINE   = 32;
  localparam int MAX_EVEN   = MAX_FINE - (MAX_FINE % 2);
  localparam int STORE_DEPTH = MAX_FINE * MAX_FINE * MAX_FINE;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int FIDX_W     = $clog2(MAX_FINE);
  localparam int N_W        = $clog2(MAX_FINE + 1);
  localparam int NN_W       = $clog2(MAX_FINE * MAX_FINE + 1);
  localparam int PROD_W     = FIDX_W + NN_W + 1;

  localparam int SAMPLE_W   = 32;
  localparam int ACC_W      = SAMPLE_W + 7;
  localparam int FS_W       = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_FINE_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_MODE = CFG_IDX_W'(1);
  localparam logic [FS_W-1:0]      FS_RESET        = FS_W'(32);

  localparam int SH_AVG  = 3;
  localparam int SH_FULL = 6;

  // neighbor offset codes along one axis
  localparam logic [1:0] OFS_NEG = 2'd0;
  localparam logic [1:0] OFS_MID = 2'd1;
  localparam logic [1:0] OFS_POS = 2'd2;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EMIT = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } bk_state_t;

  typedef struct packed {
    logic               req_type;
    logic signed [SAMPLE_W-1:0] fine_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] coarse_value;
    logic               last_of_grid;
  } out_item_t;

  typedef struct packed {
    req_kind_t          kind;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // fine index of one neighbor, wrapping periodically
  function automatic logic [FIDX_W-1:0] nbr_idx(input logic [FIDX_W-1:0] base,
                                                input logic [1:0] code,
                                                input logic [N_W-1:0] n);
    logic [FIDX_W-1:0] r;
    case (code)
      OFS_NEG: r = (base == '0) ? FIDX_W'(n - N_W'(1)) : base - FIDX_W'(1);
      OFS_POS: r = base + FIDX_W'(1);
      default: r = base;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/mgr3d_ram.sv @@
// ----------------------------------------------------------------------------
// mgr3d_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mgr3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/mgr3d_front.sv @@
// ----------------------------------------------------------------------------
// mgr3d_front
// Accepts input beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module mgr3d_front import mgr3d_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push;
  logic               pop;
  cmd_t               cmd_in;

  assign in_stall = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    cmd_in.kind   = in_data.req_type ? REQ_EMIT : REQ_LOAD;
    cmd_in.sample = in_data.fine_sample;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/mgr3d_back.sv @@
// ----------------------------------------------------------------------------
// mgr3d_back
// Holds configuration and positions, writes loads to the grid store and
// walks the stencil taps of each coarse point through the store.
// ----------------------------------------------------------------------------
module mgr3d_back import mgr3d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg_wr,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  bk_state_t         state_r, state_nxt;
  logic [FS_W-1:0]   fs_r, fs_nxt;
  logic              mode_r, mode_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [NN_W-1:0]   nn_r, nn_nxt;

  logic [ADDR_W-1:0] lpos_r, lpos_nxt;
  logic [FIDX_W-1:0] li_r, li_nxt, lj_r, lj_nxt, lk_r, lk_nxt;
  logic [FIDX_W-1:0] ci_r, ci_nxt, cj_r, cj_nxt, ck_r, ck_nxt;

  logic [FIDX_W-1:0] bi_r, bi_nxt, bj_r, bj_nxt, bk_r, bk_nxt;
  logic              wmode_r, wmode_nxt;
  logic              wlast_r, wlast_nxt;
  logic [1:0]        oi_r, oi_nxt, oj_r, oj_nxt, ok_r, ok_nxt;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              tv1_r, tv1_nxt, tv2_r;
  logic [1:0]        wsh1_r, wsh1_nxt, wsh2_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic [FS_W-1:0]     fs_raw;
  logic [FS_W+N_W-1:0] fs_cmp;
  logic [NN_W-1:0]     sq;
  logic [FIDX_W-1:0]   nm1, mm1;
  logic [FIDX_W-1:0]   ii, jj, kk;
  logic [ADDR_W-1:0]   lin;
  logic [1:0]          nz;
  logic [1:0]          lo;
  logic signed [ACC_W-1:0] tap_ext, rnd, res;
  logic                out_free;

  mgr3d_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(q_cmd.sample),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign nm1 = FIDX_W'(n_r - N_W'(1));
  assign mm1 = FIDX_W'((n_r >> 1) - N_W'(1));
  assign lo  = mode_r ? OFS_NEG : OFS_MID;

  // neighbor address for the current tap
  always_comb begin
    ii  = nbr_idx(bi_r, oi_r, n_r);
    jj  = nbr_idx(bj_r, oj_r, n_r);
    kk  = nbr_idx(bk_r, ok_r, n_r);
    lin = ADDR_W'(ii) * ADDR_W'(nn_r) + ADDR_W'(jj) * ADDR_W'(n_r) + ADDR_W'(kk);
    nz  = 2'((oi_r != OFS_MID)) + 2'((oj_r != OFS_MID)) + 2'((ok_r != OFS_MID));
  end

  // effective fine size from a config write
  always_comb begin
    fs_raw = cfg_wr.data[FS_W-1:0] & ~FS_W'(1);
    fs_cmp = (FS_W+N_W)'(fs_raw);
    if (fs_cmp < (FS_W+N_W)'(2)) begin
      n_nxt = N_W'(2);
    end else if (fs_cmp > (FS_W+N_W)'(MAX_EVEN)) begin
      n_nxt = N_W'(MAX_EVEN);
    end else begin
      n_nxt = fs_cmp[N_W-1:0];
    end
    sq = NN_W'(n_nxt) * NN_W'(n_nxt);
  end

  always_comb begin
    tap_ext = ACC_W'($signed(ram_rdata)) <<< wsh2_r;
    rnd     = acc_r + (wmode_r ? ACC_W'(1 << (SH_FULL - 1)) : ACC_W'(1 << (SH_AVG - 1)));
    res     = wmode_r ? (rnd >>> SH_FULL) : (rnd >>> SH_AVG);
  end

  always_comb begin
    state_nxt = state_r;
    fs_nxt    = fs_r;
    mode_nxt  = mode_r;
    nn_nxt    = nn_r;
    lpos_nxt  = lpos_r;
    li_nxt    = li_r;
    lj_nxt    = lj_r;
    lk_nxt    = lk_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    ck_nxt    = ck_r;
    bi_nxt    = bi_r;
    bj_nxt    = bj_r;
    bk_nxt    = bk_r;
    wmode_nxt = wmode_r;
    wlast_nxt = wlast_r;
    oi_nxt    = oi_r;
    oj_nxt    = oj_r;
    ok_nxt    = ok_r;
    addr_nxt  = addr_r;
    tv1_nxt   = 1'b0;
    wsh1_nxt  = wsh1_r;
    acc_nxt   = tv2_r ? acc_r + tap_ext : acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_r;

    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.kind == REQ_LOAD) begin
            ram_we   = 1'b1;
            ram_addr = lpos_r;
            if (li_r == nm1 && lj_r == nm1 && lk_r == nm1) begin
              lpos_nxt = '0;
              li_nxt   = '0;
              lj_nxt   = '0;
              lk_nxt   = '0;
            end else begin
              lpos_nxt = lpos_r + ADDR_W'(1);
              if (lk_r != nm1) begin
                lk_nxt = lk_r + FIDX_W'(1);
              end else begin
                lk_nxt = '0;
                if (lj_r != nm1) begin
                  lj_nxt = lj_r + FIDX_W'(1);
                end else begin
                  lj_nxt = '0;
                  li_nxt = li_r + FIDX_W'(1);
                end
              end
            end
          end else begin
            bi_nxt    = FIDX_W'({ci_r, 1'b0});
            bj_nxt    = FIDX_W'({cj_r, 1'b0});
            bk_nxt    = FIDX_W'({ck_r, 1'b0});
            wmode_nxt = mode_r;
            wlast_nxt = (ci_r == mm1) && (cj_r == mm1) && (ck_r == mm1);
            oi_nxt    = lo;
            oj_nxt    = lo;
            ok_nxt    = lo;
            acc_nxt   = '0;
            state_nxt = BK_ISSUE;
            if (ck_r != mm1) begin
              ck_nxt = ck_r + FIDX_W'(1);
            end else begin
              ck_nxt = '0;
              if (cj_r != mm1) begin
                cj_nxt = cj_r + FIDX_W'(1);
              end else begin
                cj_nxt = '0;
                ci_nxt = (ci_r != mm1) ? ci_r + FIDX_W'(1) : '0;
              end
            end
          end
        end
      end
      BK_ISSUE: begin
        addr_nxt = lin;
        tv1_nxt  = 1'b1;
        wsh1_nxt = wmode_r ? 2'(2'd3 - nz) : 2'd0;
        if (ok_r != OFS_POS) begin
          ok_nxt = ok_r + 2'd1;
        end else begin
          ok_nxt = wmode_r ? OFS_NEG : OFS_MID;
          if (oj_r != OFS_POS) begin
            oj_nxt = oj_r + 2'd1;
          end else begin
            oj_nxt = wmode_r ? OFS_NEG : OFS_MID;
            if (oi_r != OFS_POS) begin
              oi_nxt = oi_r + 2'd1;
            end else begin
              state_nxt = BK_DRAIN;
            end
          end
        end
      end
      BK_DRAIN: begin
        if (!tv1_r && !tv2_r && out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.coarse_value = res[SAMPLE_W-1:0];
          out_data_nxt.last_of_grid = wlast_r;
          state_nxt                 = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (cfg_wr.en) begin
      unique case (cfg_wr.index)
        CFG_FINE_SIZE: begin
          fs_nxt   = cfg_wr.data[FS_W-1:0];
          nn_nxt   = sq;
          lpos_nxt = '0;
          li_nxt   = '0;
          lj_nxt   = '0;
          lk_nxt   = '0;
          ci_nxt   = '0;
          cj_nxt   = '0;
          ck_nxt   = '0;
        end
        CFG_WEIGHT_MODE: begin
          mode_nxt = cfg_wr.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      fs_r        <= FS_RESET;
      mode_r      <= 1'b0;
      n_r         <= N_W'(MAX_EVEN < 32 ? MAX_EVEN : 32);
      nn_r        <= NN_W'((MAX_EVEN < 32 ? MAX_EVEN : 32) * (MAX_EVEN < 32 ? MAX_EVEN : 32));
      lpos_r      <= '0;
      li_r        <= '0;
      lj_r        <= '0;
      lk_r        <= '0;
      ci_r        <= '0;
      cj_r        <= '0;
      ck_r        <= '0;
      tv1_r       <= 1'b0;
      tv2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fs_r        <= fs_nxt;
      mode_r      <= mode_nxt;
      if (cfg_wr.en && cfg_wr.index == CFG_FINE_SIZE) begin
        n_r <= n_nxt;
      end
      nn_r        <= nn_nxt;
      lpos_r      <= lpos_nxt;
      li_r        <= li_nxt;
      lj_r        <= lj_nxt;
      lk_r        <= lk_nxt;
      ci_r        <= ci_nxt;
      cj_r        <= cj_nxt;
      ck_r        <= ck_nxt;
      tv1_r       <= tv1_nxt;
      tv2_r       <= tv1_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bi_r       <= bi_nxt;
    bj_r       <= bj_nxt;
    bk_r       <= bk_nxt;
    wmode_r    <= wmode_nxt;
    wlast_r    <= wlast_nxt;
    oi_r       <= oi_nxt;
    oj_r       <= oj_nxt;
    ok_r       <= ok_nxt;
    addr_r     <= addr_nxt;
    wsh1_r     <= wsh1_nxt;
    wsh2_r     <= wsh1_r;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/multigrid_periodic_restriction_3d.sv @@
// ----------------------------------------------------------------------------
// multigrid_periodic_restriction_3d
// Periodic 3-D restriction of a fixed-point fine grid to its coarse grid.
// ----------------------------------------------------------------------------
// Load beats fill an n x n x n periodic fine grid in raster order (k fastest);
// each emit beat returns the next coarse point, rounded to nearest, with
// last_of_grid on the final point. Beats pass a two-deep queue into a tap
// sequencer that owns the single-port grid memory: a load writes one entry,
// and an emit reads one fine sample per cycle, 8 taps in cell-average mode
// and 27 in full-weighting mode, and takes no new beat until its result is
// registered. The grid memory is not cleared after reset; emits must only
// touch entries already loaded. Writing fine_size restarts both load and
// emit positions; configuration must be written while the block is idle,
// which the block itself does not enforce.
module multigrid_periodic_restriction_3d import mgr3d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    q_valid;
  logic    q_pop;
  cmd_t    q_cmd;
  cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  mgr3d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  mgr3d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ rtl/mgr3d_checker.sv @@
// ----------------------------------------------------------------------------
// mgr3d_checker
// Port-level checks of the restriction block, bound to the top level.
// ----------------------------------------------------------------------------
module mgr3d_checker import mgr3d_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic [3:0] pend_r, pend_nxt;
  logic       emit_beat;
  logic       out_beat;

  assign emit_beat = in_valid && !in_stall && in_data.req_type;
  assign out_beat  = out_valid && !out_stall;

  // emits accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (emit_beat && !out_beat) begin
      pend_nxt = (pend_r == 4'hF) ? pend_r : pend_r + 4'd1;
    end else if (out_beat && !emit_beat) begin
      pend_nxt = (pend_r == 4'd0) ? pend_r : pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending emit");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd4)
    else $error("more emits in flight than the block can hold");

endmodule

bind multigrid_periodic_restriction_3d mgr3d_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
